// File: hdl/lba_sector_disk_port_macros.svh
// Assertion shorthands for the disk port. Both sample on the rising edge of aclk
// and are switched off while aresetn is low.
`ifndef LBA_SECTOR_DISK_PORT_MACROS_SVH
`define LBA_SECTOR_DISK_PORT_MACROS_SVH

// Same-cycle implication.
`define LBADP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LBADP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/lbadp_pkg.sv
package lbadp_pkg;

    // Bus access codes.
    localparam logic [1:0] OP_REG_WR  = 2'd0;
    localparam logic [1:0] OP_REG_RD  = 2'd1;
    localparam logic [1:0] OP_DATA_WR = 2'd2;
    localparam logic [1:0] OP_DATA_RD = 2'd3;

    // Command/status register values.
    localparam logic [7:0] STATUS_READY  = 8'h08;
    localparam logic [7:0] STATUS_WR_ERR = 8'h34;
    localparam logic [7:0] STATUS_RD_ERR = 8'h24;
    localparam logic [7:0] STATUS_DONE   = 8'h00;

    // Task register indexes that the data port uses.
    localparam logic [2:0] REG_DATA   = 3'd0;
    localparam logic [2:0] REG_COUNT  = 3'd2;
    localparam logic [2:0] REG_LBA0   = 3'd3;
    localparam logic [2:0] REG_LBA1   = 3'd4;
    localparam logic [2:0] REG_LBA2   = 3'd5;
    localparam logic [2:0] REG_LBA3   = 3'd6;
    localparam logic [2:0] REG_STATUS = 3'd7;

    localparam logic [7:0] LBA_TOP_MASK = 8'h0F;

    localparam int NUM_REGS      = 8;
    localparam int SECTOR_BYTES  = 512;
    localparam int SECTOR_SHIFT  = 9;
    localparam int LBA_W         = 28;
    localparam int CNT_W         = 18;
    localparam int MEM_BYTES_DEF = 1048576;

    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] reg_index;
        logic [7:0] write_value;
    } item_t;

    typedef struct packed {
        logic [7:0] read_value;
        logic [7:0] status_value;
        logic       save_request;
        logic       use_mem;        // read_value comes from the store read data
    } res_t;

    typedef struct packed {
        logic wr;
        logic rd;
    } mreq_t;

endpackage

// File: hdl/lba_sector_disk_port.sv
// An accepted item waits in the input register, then its result is registered.
// Throughput: one item per cycle unless m_tready stalls; each item makes at most
// one access to the single-port byte store, whose registered read data feeds the
// result. Reset: task registers, byte counter and handshake state clear at once;
// then a clearing pass zeroes all MEM_BYTES bytes of the store (1048576 by
// default), one byte per cycle, while s_tready stays low.
`include "lba_sector_disk_port_macros.svh"

module lba_sector_disk_port #(
    parameter int MEM_BYTES = lbadp_pkg::MEM_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] write_value
    input  logic [4:0]  s_tuser,    // [1:0] opcode, [4:2] reg_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] read_value, [15:8] status_value
    output logic [0:0]  m_tuser     // [0] save_request
);

    localparam int ADDR_W = $clog2(MEM_BYTES);
    localparam logic [ADDR_W-1:0] MEM_LAST = ADDR_W'(MEM_BYTES - 1);

    lbadp_pkg::item_t  in_item_reg;
    logic              in_valid_reg;
    lbadp_pkg::res_t   out_res_reg;
    logic              out_valid_reg;
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              proc;
    lbadp_pkg::res_t   core_res;
    lbadp_pkg::mreq_t  core_mreq;
    logic [ADDR_W-1:0] core_addr;
    logic [7:0]        core_wdata;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_wdata;
    logic [7:0]        mem_q;

    // The held item runs when the result register is free or being emptied.
    assign proc     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !clearing_reg && (!in_valid_reg || proc);

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (proc) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.opcode      <= s_tuser[1:0];
            in_item_reg.reg_index   <= s_tuser[4:2];
            in_item_reg.write_value <= s_tdata;
        end
    end

    // Clearing pass over the store after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clearing_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == MEM_LAST) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    lbadp_core #(
        .MEM_BYTES (MEM_BYTES),
        .ADDR_W    (ADDR_W)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .proc      (proc),
        .item      (in_item_reg),
        .mem_q     (mem_q),
        .res       (core_res),
        .mreq      (core_mreq),
        .mem_addr  (core_addr),
        .mem_wdata (core_wdata)
    );

    // The clearing pass owns the store port until it finishes.
    assign mem_we    = clearing_reg || core_mreq.wr;
    assign mem_addr  = clearing_reg ? clr_cnt_reg : core_addr;
    assign mem_wdata = clearing_reg ? 8'h00 : core_wdata;

    lbadp_store #(
        .DEPTH  (MEM_BYTES),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (core_mreq.rd),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_q)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            out_res_reg <= core_res;
        end
    end

    // A data read takes its byte straight from the store read register.
    assign m_tvalid      = out_valid_reg;
    assign m_tdata[7:0]  = out_res_reg.use_mem ? mem_q : out_res_reg.read_value;
    assign m_tdata[15:8] = out_res_reg.status_value;
    assign m_tuser[0]    = out_res_reg.save_request;

    `LBADP_ASSERT_NOW(a_no_accept_clearing, clearing_reg, !s_tready, "item taken during clear")
    `LBADP_ASSERT_NOW(a_store_write_src, mem_we && !clearing_reg, in_item_reg.opcode == lbadp_pkg::OP_DATA_WR, "store written by non-write item")
    `LBADP_ASSERT_NEXT(a_read_to_result, proc && core_mreq.rd, out_valid_reg && out_res_reg.use_mem, "store read lost its result")
    `LBADP_ASSERT_NOW(a_save_done, out_valid_reg && out_res_reg.save_request, out_res_reg.status_value == lbadp_pkg::STATUS_DONE, "save request without done status")

endmodule

// File: hdl/lbadp_store.sv
module lbadp_store #(
    parameter int DEPTH  = lbadp_pkg::MEM_BYTES_DEF,
    parameter int ADDR_W = $clog2(lbadp_pkg::MEM_BYTES_DEF)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [7:0]        wdata,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // Single-port byte store with registered read data.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/lbadp_core.sv
module lbadp_core #(
    parameter int MEM_BYTES = lbadp_pkg::MEM_BYTES_DEF,
    parameter int ADDR_W    = $clog2(lbadp_pkg::MEM_BYTES_DEF)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 proc,
    input  lbadp_pkg::item_t     item,
    input  logic [7:0]           mem_q,
    output lbadp_pkg::res_t      res,
    output lbadp_pkg::mreq_t     mreq,
    output logic [ADDR_W-1:0]    mem_addr,
    output logic [7:0]           mem_wdata
);

    localparam logic [lbadp_pkg::LBA_W-1:0] LBA_LIMIT =
        lbadp_pkg::LBA_W'((MEM_BYTES + lbadp_pkg::SECTOR_BYTES - 1) / lbadp_pkg::SECTOR_BYTES);
    localparam logic [ADDR_W:0]   MEM_SIZE = (ADDR_W + 1)'(MEM_BYTES);
    localparam logic [ADDR_W-1:0] MEM_LAST = ADDR_W'(MEM_BYTES - 1);
    localparam int START_W = lbadp_pkg::LBA_W + lbadp_pkg::SECTOR_SHIFT;

    logic [7:0]                   regs_reg  [lbadp_pkg::NUM_REGS];
    logic [7:0]                   regs_eff  [lbadp_pkg::NUM_REGS];
    logic [7:0]                   regs_next [lbadp_pkg::NUM_REGS];
    logic [lbadp_pkg::CNT_W-1:0]  cnt_reg, cnt_next, cnt_inc, limit;
    logic [ADDR_W-1:0]            cmod_reg, cmod_next;
    logic                         pend_reg, pend_next;
    logic [lbadp_pkg::LBA_W-1:0]  lba;
    logic [START_W-1:0]           start_w;
    logic [ADDR_W:0]              idx_sum;
    logic                         start_bad;
    logic                         is_data, is_write;
    logic [7:0]                   lba_top;

    // Address and limit arithmetic from the current task registers.
    always_comb begin
        for (int i = 0; i < lbadp_pkg::NUM_REGS; i++) begin
            regs_eff[i] = regs_reg[i];
        end
        // A data read of the previous item lands in the data register now.
        if (pend_reg) begin
            regs_eff[lbadp_pkg::REG_DATA] = mem_q;
        end
        lba_top   = regs_eff[lbadp_pkg::REG_LBA3] & lbadp_pkg::LBA_TOP_MASK;
        lba       = {lba_top[3:0], regs_eff[lbadp_pkg::REG_LBA2],
                     regs_eff[lbadp_pkg::REG_LBA1], regs_eff[lbadp_pkg::REG_LBA0]};
        start_bad = (lba >= LBA_LIMIT);
        start_w   = {lba, {lbadp_pkg::SECTOR_SHIFT{1'b0}}};
        idx_sum   = {1'b0, start_w[ADDR_W-1:0]} + {1'b0, cmod_reg};
        if (idx_sum >= MEM_SIZE) begin
            idx_sum = idx_sum - MEM_SIZE;
        end
        cnt_inc = cnt_reg + 1'b1;
        limit   = {1'b0, regs_eff[lbadp_pkg::REG_COUNT], {lbadp_pkg::SECTOR_SHIFT{1'b0}}};
    end

    assign mem_addr  = idx_sum[ADDR_W-1:0];
    assign mem_wdata = item.write_value;

    // Access decode and transfer control for one item.
    always_comb begin
        for (int i = 0; i < lbadp_pkg::NUM_REGS; i++) begin
            regs_next[i] = regs_eff[i];
        end
        cnt_next  = cnt_reg;
        cmod_next = cmod_reg;
        pend_next = 1'b0;
        res       = '0;
        mreq      = '0;
        is_data   = 1'b0;
        is_write  = 1'b0;

        if (proc) begin
            unique case (item.opcode)
                lbadp_pkg::OP_REG_WR: begin
                    regs_next[item.reg_index] = item.write_value;
                end
                lbadp_pkg::OP_REG_RD: begin
                    res.read_value = regs_eff[item.reg_index];
                end
                lbadp_pkg::OP_DATA_WR: begin
                    regs_next[lbadp_pkg::REG_DATA] = item.write_value;
                    is_data  = 1'b1;
                    is_write = 1'b1;
                end
                lbadp_pkg::OP_DATA_RD: begin
                    res.read_value = regs_eff[lbadp_pkg::REG_DATA];
                    is_data = 1'b1;
                end
            endcase
        end

        // The data port moves a byte only while the status shows ready.
        if (is_data && regs_eff[lbadp_pkg::REG_STATUS] == lbadp_pkg::STATUS_READY) begin
            if (start_bad) begin
                regs_next[lbadp_pkg::REG_STATUS] = is_write ? lbadp_pkg::STATUS_WR_ERR
                                                            : lbadp_pkg::STATUS_RD_ERR;
                cnt_next  = '0;
                cmod_next = '0;
            end else begin
                mreq.wr     = is_write;
                mreq.rd     = !is_write;
                pend_next   = !is_write;
                res.use_mem = !is_write;
                if (cnt_inc > limit) begin
                    regs_next[lbadp_pkg::REG_STATUS] = lbadp_pkg::STATUS_DONE;
                    cnt_next         = '0;
                    cmod_next        = '0;
                    res.save_request = is_write;
                end else begin
                    cnt_next  = cnt_inc;
                    cmod_next = (cmod_reg == MEM_LAST) ? '0 : cmod_reg + 1'b1;
                end
            end
        end

        res.status_value = regs_next[lbadp_pkg::REG_STATUS];
    end

    // Task registers, byte counter, its wrapped copy and the pending-read flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < lbadp_pkg::NUM_REGS; i++) begin
                regs_reg[i] <= '0;
            end
            cnt_reg  <= '0;
            cmod_reg <= '0;
            pend_reg <= 1'b0;
        end else begin
            for (int i = 0; i < lbadp_pkg::NUM_REGS; i++) begin
                regs_reg[i] <= regs_next[i];
            end
            cnt_reg  <= cnt_next;
            cmod_reg <= cmod_next;
            pend_reg <= pend_next;
        end
    end

endmodule
